// ----- hw/rtl/qdr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quorum disk reservation package
// Shared types, state encoding and register indexes for the tie-breaker block.
// ----------------------------------------------------------------------------
package qdr_pkg;

  localparam int unsigned NodesW   = 8;
  localparam int unsigned TimeoutW = 32;
  localparam int unsigned VotesW   = 8;
  localparam int unsigned TimeW    = 64;
  localparam int unsigned CodeW    = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] RegClusterNodes = 1'b0;
  localparam logic [CfgIdxW-1:0] RegTimeoutMs    = 1'b1;

  localparam logic [CodeW-1:0] CodeStart   = 3'd0;
  localparam logic [CodeW-1:0] CodeIdle    = 3'd1;
  localparam logic [CodeW-1:0] CodeReserve = 3'd2;
  localparam logic [CodeW-1:0] CodeRecv    = 3'd3;
  localparam logic [CodeW-1:0] CodeHave    = 3'd4;
  localparam logic [CodeW-1:0] CodeRelease = 3'd5;
  localparam logic [CodeW-1:0] CodeHalt    = 3'd6;

  typedef enum logic [6:0] {
    ST_START   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_RESERVE = 7'b0000100,
    ST_RECV    = 7'b0001000,
    ST_HAVE    = 7'b0010000,
    ST_RELEASE = 7'b0100000,
    ST_HALT    = 7'b1000000
  } qdr_state_e;

  typedef struct packed {
    logic [NodesW-1:0]   cluster_nodes;
    logic [TimeoutW-1:0] timeout_ms;
  } qdr_cfg_t;

  typedef struct packed {
    logic              quorate;
    logic [VotesW-1:0] vote_total;
    logic              disk_reserved;
    logic              recv_vote_flag;
    logic              keys_valid;
    logic              reserve_ok;
    logic              release_ok;
    logic [TimeW-1:0]  now_ms;
  } qdr_poll_t;

  typedef struct packed {
    logic [CodeW-1:0] next_state;
    logic             state_changed;
    logic             abort_reservation;
    logic             reserve_attempt;
    logic             cast_vote;
    logic             release_attempt;
    logic             fatal;
  } qdr_result_t;

  function automatic logic [CodeW-1:0] state_code(input qdr_state_e st);
    logic [CodeW-1:0] code;
    unique case (st)
      ST_START:   code = CodeStart;
      ST_IDLE:    code = CodeIdle;
      ST_RESERVE: code = CodeReserve;
      ST_RECV:    code = CodeRecv;
      ST_HAVE:    code = CodeHave;
      ST_RELEASE: code = CodeRelease;
      default:    code = CodeHalt;
    endcase
    return code;
  endfunction

endpackage

// ----- hw/rtl/qdr_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quorum disk reservation channels
// Poll and result word channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface qdr_in_if
  import qdr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              quorate;
  logic [VotesW-1:0] vote_total;
  logic              disk_reserved;
  logic              recv_vote_flag;
  logic              keys_valid;
  logic              reserve_ok;
  logic              release_ok;
  logic [TimeW-1:0]  now_ms;

  modport source (
    output valid, quorate, vote_total, disk_reserved, recv_vote_flag,
           keys_valid, reserve_ok, release_ok, now_ms,
    input  ready
  );
  modport sink (
    input  valid, quorate, vote_total, disk_reserved, recv_vote_flag,
           keys_valid, reserve_ok, release_ok, now_ms,
    output ready
  );
endinterface

interface qdr_out_if
  import qdr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] next_state;
  logic             state_changed;
  logic             abort_reservation;
  logic             reserve_attempt;
  logic             cast_vote;
  logic             release_attempt;
  logic             fatal;

  modport source (
    output valid, next_state, state_changed, abort_reservation,
           reserve_attempt, cast_vote, release_attempt, fatal,
    input  ready
  );
  modport sink (
    input  valid, next_state, state_changed, abort_reservation,
           reserve_attempt, cast_vote, release_attempt, fatal,
    output ready
  );
endinterface

// ----- hw/rtl/qdr_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quorum disk reservation configuration registers
// Holds the node count and timeout written through the plain write port.
// ----------------------------------------------------------------------------
module qdr_cfg_regs
  import qdr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output qdr_cfg_t            cfg_o
);

  logic [NodesW-1:0]   nodes_q;
  logic [TimeoutW-1:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_q   <= '0;
      timeout_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegClusterNodes: nodes_q   <= cfg_data_i[NodesW-1:0];
        RegTimeoutMs:    timeout_q <= cfg_data_i[TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.cluster_nodes = nodes_q;
  assign cfg_o.timeout_ms    = timeout_q;

endmodule

// ----- hw/rtl/qdr_fsm_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quorum disk reservation state machine
// Tie-breaker state and deadline with the per-poll next-state logic.
// ----------------------------------------------------------------------------
module qdr_fsm_core
  import qdr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  qdr_poll_t   poll_i,
  input  qdr_cfg_t    cfg_i,
  output qdr_result_t res_o
);

  qdr_state_e       state_q, state_d;
  logic [TimeW-1:0] deadline_q, deadline_d;

  logic [VotesW:0]   votes_x2;
  logic [NodesW-1:0] majority;
  logic              tie;
  logic              has_majority;
  logic              expired;
  logic [TimeW-1:0]  new_deadline;

  assign votes_x2     = {poll_i.vote_total, 1'b0};
  assign majority     = (cfg_i.cluster_nodes >> 1) + NodesW'(1);
  assign tie          = (votes_x2 == {1'b0, cfg_i.cluster_nodes});
  assign has_majority = (poll_i.vote_total == majority);
  assign expired      = (poll_i.now_ms > deadline_q);
  assign new_deadline = poll_i.now_ms + {{(TimeW-TimeoutW){1'b0}}, cfg_i.timeout_ms};

  always_comb begin
    state_d    = state_q;
    deadline_d = deadline_q;
    res_o      = '0;
    unique case (state_q)
      ST_START: begin
        if (!poll_i.keys_valid) begin
          res_o.fatal = 1'b1;
          state_d     = ST_HALT;
        end else if (poll_i.quorate) begin
          res_o.abort_reservation = poll_i.disk_reserved;
          state_d                 = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!poll_i.keys_valid) begin
          res_o.fatal = 1'b1;
          state_d     = ST_HALT;
        end else if (tie && !poll_i.disk_reserved) begin
          deadline_d = new_deadline;
          state_d    = ST_RESERVE;
        end else if (poll_i.recv_vote_flag) begin
          deadline_d = new_deadline;
          state_d    = ST_RECV;
        end
      end
      ST_RESERVE: begin
        res_o.reserve_attempt = 1'b1;
        if (poll_i.reserve_ok) begin
          res_o.cast_vote = 1'b1;
          state_d         = ST_HAVE;
        end else if (expired) begin
          state_d = ST_IDLE;
        end else if (poll_i.recv_vote_flag) begin
          state_d = ST_RECV;
        end
      end
      ST_RECV: begin
        if (poll_i.recv_vote_flag) begin
          deadline_d = new_deadline;
        end else if (expired) begin
          state_d = ST_IDLE;
        end
      end
      ST_HAVE: begin
        res_o.reserve_attempt = 1'b1;
        if (poll_i.reserve_ok && has_majority) begin
          res_o.cast_vote = 1'b1;
        end else if (!has_majority) begin
          state_d = ST_RELEASE;
        end
      end
      ST_RELEASE: begin
        res_o.release_attempt = 1'b1;
        if (poll_i.release_ok) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_HALT;
      end
    endcase
    res_o.next_state    = state_code(state_d);
    res_o.state_changed = (state_d != state_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_START;
      deadline_q <= '0;
    end else if (step_i) begin
      state_q    <= state_d;
      deadline_q <= deadline_d;
    end
  end

  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && state_q == ST_HALT) |=> (state_q == ST_HALT))
    else $error("halted state was left");

  a_fatal_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.fatal) |=> (state_q == ST_HALT && $stable(deadline_q)))
    else $error("fatal poll did not halt or moved the deadline");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(state_q) && $stable(deadline_q)))
    else $error("state changed without a poll");

endmodule

// ----- hw/rtl/quorum_disk_reservation_fsm_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quorum disk reservation tie-breaker unit
// Throughput is one poll word per cycle while the result side keeps taking.
// The poll register feeds the state machine logic, whose result is registered.
// Reset puts the machine in the start state with a zero deadline and clears
// the configuration registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
module quorum_disk_reservation_fsm_unit
  import qdr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  qdr_in_if.sink              in_if,
  qdr_out_if.source           out_if
);

  qdr_cfg_t    cfg;
  qdr_poll_t   poll_q;
  logic        poll_valid_q;
  qdr_result_t res;
  qdr_result_t res_q;
  logic        res_valid_q;
  logic        advance;
  logic        in_take;

  assign advance  = !res_valid_q || out_if.ready;
  assign in_if.ready = !poll_valid_q || advance;
  assign in_take  = in_if.valid && in_if.ready;

  qdr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  qdr_fsm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (poll_valid_q && advance),
    .poll_i (poll_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (in_if.ready) begin
        poll_valid_q <= in_if.valid;
      end
      if (advance) begin
        res_valid_q <= poll_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      poll_q.quorate        <= in_if.quorate;
      poll_q.vote_total     <= in_if.vote_total;
      poll_q.disk_reserved  <= in_if.disk_reserved;
      poll_q.recv_vote_flag <= in_if.recv_vote_flag;
      poll_q.keys_valid     <= in_if.keys_valid;
      poll_q.reserve_ok     <= in_if.reserve_ok;
      poll_q.release_ok     <= in_if.release_ok;
      poll_q.now_ms         <= in_if.now_ms;
    end
    if (advance && poll_valid_q) begin
      res_q <= res;
    end
  end

  assign out_if.valid             = res_valid_q;
  assign out_if.next_state        = res_q.next_state;
  assign out_if.state_changed     = res_q.state_changed;
  assign out_if.abort_reservation = res_q.abort_reservation;
  assign out_if.reserve_attempt   = res_q.reserve_attempt;
  assign out_if.cast_vote         = res_q.cast_vote;
  assign out_if.release_attempt   = res_q.release_attempt;
  assign out_if.fatal             = res_q.fatal;

endmodule

// ----- tb/sv/tb_quorum_disk_reservation_fsm_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the quorum disk reservation tie-breaker unit
// Poll words go in through a bursty driver and result words are taken by a
// stalling monitor. A local model of the tie-breaker predicts each result
// word when its poll word is accepted. Runs a directed walk through every
// state but halt, then randomized phases under several register settings.
// It ends with a key check failure that halts the machine.
// ----------------------------------------------------------------------------
module tb_quorum_disk_reservation_fsm_unit;
  import qdr_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  qdr_in_if  poll_if ();
  qdr_out_if result_if ();

  quorum_disk_reservation_fsm_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (poll_if),
    .out_if     (result_if)
  );

  always #5 clk_i = ~clk_i;

  qdr_poll_t   pending_polls[$];
  qdr_result_t expected_results[$];

  logic [NodesW-1:0]   nodes_cfg;
  logic [TimeoutW-1:0] timeout_cfg;

  logic [CodeW-1:0] model_code;
  logic [TimeW-1:0] model_deadline;
  logic [CodeW-1:0] plan_code;
  logic [TimeW-1:0] plan_deadline;
  logic [TimeW-1:0] plan_clock;

  int unsigned bad_results;
  int unsigned result_count;
  int unsigned cycle_count;

  qdr_poll_t   poll_on_wire;
  qdr_poll_t   next_poll;
  logic        drive_poll;
  int unsigned burst_left;
  int unsigned gap_left;

  logic [31:0] stall_pattern;
  logic [4:0]  pattern_pos;

  function automatic qdr_result_t tiebreak_poll(
    input  logic [CodeW-1:0]    code,
    input  logic [TimeW-1:0]    deadline,
    input  logic [NodesW-1:0]   nodes,
    input  logic [TimeoutW-1:0] tmo,
    input  qdr_poll_t           p,
    output logic [CodeW-1:0]    code_n,
    output logic [TimeW-1:0]    deadline_n
  );
    qdr_result_t       r;
    logic [VotesW-1:0] majority;
    logic              tie;
    r          = '0;
    code_n     = code;
    deadline_n = deadline;
    majority   = (nodes >> 1) + 8'd1;
    tie        = ({p.vote_total, 1'b0} == {1'b0, nodes});
    case (code)
      CodeStart: begin
        if (!p.keys_valid) begin
          r.fatal = 1'b1;
          code_n  = CodeHalt;
        end else if (p.quorate) begin
          r.abort_reservation = p.disk_reserved;
          code_n              = CodeIdle;
        end
      end
      CodeIdle: begin
        if (!p.keys_valid) begin
          r.fatal = 1'b1;
          code_n  = CodeHalt;
        end else if (tie && !p.disk_reserved) begin
          deadline_n = p.now_ms + 64'(tmo);
          code_n     = CodeReserve;
        end else if (p.recv_vote_flag) begin
          deadline_n = p.now_ms + 64'(tmo);
          code_n     = CodeRecv;
        end
      end
      CodeReserve: begin
        r.reserve_attempt = 1'b1;
        if (p.reserve_ok) begin
          r.cast_vote = 1'b1;
          code_n      = CodeHave;
        end else if (p.now_ms > deadline) begin
          code_n = CodeIdle;
        end else if (p.recv_vote_flag) begin
          code_n = CodeRecv;
        end
      end
      CodeRecv: begin
        if (p.recv_vote_flag) begin
          deadline_n = p.now_ms + 64'(tmo);
        end else if (p.now_ms > deadline) begin
          code_n = CodeIdle;
        end
      end
      CodeHave: begin
        r.reserve_attempt = 1'b1;
        if (p.reserve_ok && p.vote_total == majority) begin
          r.cast_vote = 1'b1;
        end else if (p.vote_total != majority) begin
          code_n = CodeRelease;
        end
      end
      CodeRelease: begin
        r.release_attempt = 1'b1;
        if (p.release_ok) begin
          code_n = CodeIdle;
        end
      end
      default: begin
        code_n = CodeHalt;
      end
    endcase
    r.next_state    = code_n;
    r.state_changed = (code_n != code);
    return r;
  endfunction

  function automatic qdr_poll_t poll_of(
    input int unsigned      quorate,
    input int unsigned      votes,
    input int unsigned      reserved,
    input int unsigned      recv,
    input int unsigned      keys,
    input int unsigned      res_ok,
    input int unsigned      rel_ok,
    input logic [TimeW-1:0] now
  );
    qdr_poll_t p;
    p.quorate        = 1'(quorate);
    p.vote_total     = VotesW'(votes);
    p.disk_reserved  = 1'(reserved);
    p.recv_vote_flag = 1'(recv);
    p.keys_valid     = 1'(keys);
    p.reserve_ok     = 1'(res_ok);
    p.release_ok     = 1'(rel_ok);
    p.now_ms         = now;
    return p;
  endfunction

  function automatic qdr_poll_t shape_poll(input logic allow_key_fault);
    qdr_poll_t         p;
    logic [VotesW-1:0] majority;
    majority = (nodes_cfg >> 1) + 8'd1;
    p = poll_of($urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 1),
                $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                $urandom_range(0, 1), {$urandom, $urandom});
    if ($urandom_range(0, 9) != 0) begin
      case (plan_code)
        CodeStart: p.quorate = ($urandom_range(0, 3) != 0);
        CodeIdle: begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: p.vote_total = nodes_cfg >> 1;
            4:          p.vote_total = majority;
            default:    p.vote_total = VotesW'($urandom_range(0, 255));
          endcase
          p.disk_reserved  = ($urandom_range(0, 2) == 0);
          p.recv_vote_flag = ($urandom_range(0, 3) == 0);
        end
        CodeReserve: begin
          p.reserve_ok     = ($urandom_range(0, 3) == 0);
          p.recv_vote_flag = ($urandom_range(0, 3) == 0);
        end
        CodeHave: begin
          if ($urandom_range(0, 4) != 0) p.vote_total = majority;
        end
        CodeRelease: p.release_ok = ($urandom_range(0, 2) == 0);
        default: ;
      endcase
      case ($urandom_range(0, 5))
        0: p.now_ms = plan_deadline - 64'd1;
        1: p.now_ms = plan_deadline;
        2: p.now_ms = plan_deadline + 64'd1;
        3, 4: begin
          plan_clock = plan_clock + 64'($urandom_range(0, 50));
          p.now_ms   = plan_clock;
        end
        default: ;
      endcase
    end
    if (!allow_key_fault && (plan_code == CodeStart || plan_code == CodeIdle)) begin
      p.keys_valid = 1'b1;
    end
    return p;
  endfunction

  task automatic push_poll(input qdr_poll_t p);
    void'(tiebreak_poll(plan_code, plan_deadline, nodes_cfg, timeout_cfg, p,
                        plan_code, plan_deadline));
    pending_polls.push_back(p);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == RegClusterNodes) begin
      nodes_cfg = data[NodesW-1:0];
    end else begin
      timeout_cfg = data[TimeoutW-1:0];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_polls.size() != 0 || poll_if.valid || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_if.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (poll_if.valid && poll_if.ready) begin
        expected_results.push_back(tiebreak_poll(model_code, model_deadline, nodes_cfg,
                                                 timeout_cfg, poll_on_wire, model_code,
                                                 model_deadline));
      end
      if (!poll_if.valid || poll_if.ready) begin
        drive_poll = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_polls.size() != 0) begin
          next_poll  = pending_polls.pop_front();
          drive_poll = 1'b1;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
        poll_if.valid <= drive_poll;
        if (drive_poll) begin
          poll_on_wire                 = next_poll;
          poll_if.quorate             <= next_poll.quorate;
          poll_if.vote_total          <= next_poll.vote_total;
          poll_if.disk_reserved       <= next_poll.disk_reserved;
          poll_if.recv_vote_flag      <= next_poll.recv_vote_flag;
          poll_if.keys_valid          <= next_poll.keys_valid;
          poll_if.reserve_ok          <= next_poll.reserve_ok;
          poll_if.release_ok          <= next_poll.release_ok;
          poll_if.now_ms              <= next_poll.now_ms;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    qdr_result_t want;
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      stall_pattern   <= '1;
      pattern_pos     <= '0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("result word %0d arrived with nothing expected", result_count);
          end
        end else begin
          want = expected_results.pop_front();
          if (result_if.next_state !== want.next_state
              || result_if.state_changed !== want.state_changed
              || result_if.abort_reservation !== want.abort_reservation
              || result_if.reserve_attempt !== want.reserve_attempt
              || result_if.cast_vote !== want.cast_vote
              || result_if.release_attempt !== want.release_attempt
              || result_if.fatal !== want.fatal) begin
            bad_results++;
            if (bad_results <= 10) begin
              $display("word %0d exp st=%0d chg=%b abt=%b res=%b vote=%b rel=%b fat=%b",
                       result_count, want.next_state, want.state_changed,
                       want.abort_reservation, want.reserve_attempt, want.cast_vote,
                       want.release_attempt, want.fatal);
              $display("word %0d got st=%0d chg=%b abt=%b res=%b vote=%b rel=%b fat=%b",
                       result_count, result_if.next_state, result_if.state_changed,
                       result_if.abort_reservation, result_if.reserve_attempt,
                       result_if.cast_vote, result_if.release_attempt, result_if.fatal);
            end
          end
        end
      end
      if (pattern_pos == '0) begin
        case ($urandom_range(0, 3))
          0:       stall_pattern <= '1;
          1:       stall_pattern <= $urandom | $urandom;
          2:       stall_pattern <= $urandom;
          default: stall_pattern <= $urandom & $urandom;
        endcase
        result_if.ready <= 1'b1;
      end else begin
        result_if.ready <= stall_pattern[pattern_pos];
      end
      pattern_pos <= pattern_pos + 5'd1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  logic [NodesW-1:0]   phase_nodes[8];
  logic [TimeoutW-1:0] phase_timeout[8];
  qdr_poll_t           fault_poll;
  int unsigned         guard;

  initial begin
    cfg_we_i                 = 1'b0;
    cfg_idx_i                = RegClusterNodes;
    cfg_data_i               = '0;
    poll_if.valid            = 1'b0;
    poll_if.quorate          = 1'b0;
    poll_if.vote_total       = '0;
    poll_if.disk_reserved    = 1'b0;
    poll_if.recv_vote_flag   = 1'b0;
    poll_if.keys_valid       = 1'b1;
    poll_if.reserve_ok       = 1'b0;
    poll_if.release_ok       = 1'b0;
    poll_if.now_ms           = '0;
    result_if.ready          = 1'b0;
    nodes_cfg                = '0;
    timeout_cfg              = '0;
    model_code               = CodeStart;
    model_deadline           = '0;
    plan_code                = CodeStart;
    plan_deadline            = '0;
    plan_clock               = '0;
    bad_results              = 0;
    result_count             = 0;
    cycle_count              = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(RegClusterNodes, {24'($urandom_range(0, 16777215)), 8'd4});
    write_reg(RegTimeoutMs, 32'd10);
    push_poll(poll_of(0, 0, 0, 0, 1, 1, 1, 64'd0));
    push_poll(poll_of(1, 0, 1, 0, 1, 0, 0, 64'd1));
    push_poll(poll_of(0, 2, 1, 0, 1, 0, 0, 64'd50));
    push_poll(poll_of(0, 2, 0, 0, 1, 0, 0, 64'd100));
    push_poll(poll_of(0, 2, 0, 0, 1, 0, 0, 64'd110));
    push_poll(poll_of(0, 2, 0, 0, 1, 0, 0, 64'd111));
    push_poll(poll_of(0, 1, 0, 1, 1, 0, 0, 64'd200));
    push_poll(poll_of(0, 1, 0, 1, 1, 0, 0, 64'd205));
    push_poll(poll_of(0, 1, 0, 0, 1, 0, 0, 64'd215));
    push_poll(poll_of(0, 1, 0, 0, 1, 0, 0, 64'd216));
    push_poll(poll_of(0, 2, 0, 0, 1, 0, 0, 64'd300));
    push_poll(poll_of(0, 2, 0, 1, 1, 0, 0, 64'd300));
    push_poll(poll_of(0, 2, 0, 0, 1, 0, 0, 64'd400));
    push_poll(poll_of(0, 2, 0, 0, 1, 0, 0, 64'd500));
    push_poll(poll_of(1, 2, 1, 1, 0, 1, 1, 64'd999));
    push_poll(poll_of(0, 3, 0, 0, 1, 1, 0, 64'd1000));
    push_poll(poll_of(0, 3, 0, 0, 1, 0, 0, 64'd1001));
    push_poll(poll_of(0, 255, 0, 0, 1, 1, 0, 64'd1002));
    push_poll(poll_of(0, 255, 0, 0, 1, 0, 0, 64'd1003));
    push_poll(poll_of(0, 255, 0, 0, 1, 0, 1, 64'd1004));
    push_poll(poll_of(1, 255, 1, 0, 1, 1, 1, '1));
    push_poll(poll_of(0, 255, 1, 1, 1, 0, 0, '1));
    push_poll(poll_of(0, 0, 0, 0, 1, 0, 0, 64'd10));
    drain();

    phase_nodes   = '{8'd0, 8'd255, 8'd4, 8'd5, 8'd255, 8'd1, 8'd2,
                      8'($urandom_range(0, 255))};
    phase_timeout = '{32'd0, '1, 32'd10, 32'd1000, 32'd0, '1,
                      32'($urandom_range(0, 100)), $urandom};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(RegClusterNodes, {24'($urandom_range(0, 16777215)), phase_nodes[ph]});
      write_reg(RegTimeoutMs, phase_timeout[ph]);
      plan_clock = $urandom_range(0, 1) ? {$urandom, $urandom}
                                        : 64'($urandom_range(0, 1000));
      repeat (185) push_poll(shape_poll(1'b0));
      drain();
    end

    guard = 0;
    while (plan_code != CodeIdle && guard < 500) begin
      push_poll(shape_poll(1'b0));
      guard++;
    end
    fault_poll               = shape_poll(1'b0);
    fault_poll.vote_total    = nodes_cfg >> 1;
    fault_poll.disk_reserved = 1'b0;
    fault_poll.keys_valid    = 1'b0;
    push_poll(fault_poll);
    repeat (20) push_poll(shape_poll(1'b1));
    drain();

    repeat (10) @(posedge clk_i);
    if (bad_results == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
